>>> src/text_row_dot_rasterizer_macros.svh
// assertion macros for the text row dot rasterizer checker
// depends on clk and rst_n being visible where the macros are used
`ifndef TEXT_ROW_DOT_RASTERIZER_MACROS_SVH
`define TEXT_ROW_DOT_RASTERIZER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/trd_pkg.sv
// shared constants for the text row dot rasterizer
// no dependencies
`default_nettype none

package trd_pkg;

  // request commands
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_RENDER = 2'd1;
  localparam logic [1:0] CMD_EOL    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FONT_KIND    = 2'd0;
  localparam logic [1:0] CFG_FONT_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_DOUBLE_WIDTH = 2'd2;

  // font kinds
  localparam logic [1:0] KIND_12ROW = 2'd1;
  localparam logic [1:0] KIND_16ROW = 2'd2;

  localparam int GROUP_DOTS   = 24;
  localparam int MAX_GROUPS   = 16;
  localparam int MAX_COLS     = 12;
  localparam int NARROW_COLS  = 8;
  localparam int REGION_WORDS = 4096;
  localparam int ADDR_SPAN    = 16384;

endpackage

`default_nettype wire

>>> src/trd_ram.sv
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module trd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> src/text_row_dot_rasterizer.sv
// text row dot rasterizer: one request at a time, in_stall high while one is in progress
// a font write goes to the store as it is taken; render: the glyph start address is wrapped,
// the columns (font_width capped at 12) are read and the group is loaded into the output
// register once it is free; end of line emits up to 16 groups, one per cycle while the
// result side takes them; synchronous active-low reset clears control and the dot position and
// sets font width 8, other settings 0; the font store is undefined until written (trd_pkg, trd_ram)
`default_nettype none

module text_row_dot_rasterizer #(
  parameter int LINE_DOTS  = 384,
  parameter int FONT_WORDS = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [13:0] in_font_address,
  input  wire logic [15:0] in_font_word,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [3:0]  in_row,

  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_dot_bits,
  output logic [4:0]       out_dot_count,
  output logic             out_line_end,

  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  localparam int AW         = $clog2(FONT_WORDS);
  localparam int PW         = $clog2(LINE_DOTS + 1);
  // font addresses never exceed the 14-bit request span, so ADDR_SPAN / FONT_WORDS subtractions wrap them
  localparam int FOLD_STEPS = trd_pkg::ADDR_SPAN / FONT_WORDS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,   // waiting for a request
    ST_ADDR = 5'b00010,   // wrapping the glyph start address
    ST_READ = 5'b00100,   // one column read per cycle, data back in the cycle after its read
    ST_EMIT = 5'b01000,   // handing the group to the output register
    ST_EOL  = 5'b10000    // padding groups to the end of the line
  } st_t;

  // wrap an address into the font store
  function automatic logic [AW-1:0] fold_addr(input logic [13:0] raw);
    logic [16:0] v;
    v = 17'(raw);
    for (int i = 0; i < FOLD_STEPS; i++) begin
      if (v >= 17'(FONT_WORDS)) begin
        v = v - 17'(FONT_WORDS);
      end
    end
    return v[AW-1:0];
  endfunction

  st_t state_r, state_nxt;

  // configuration
  logic [1:0] kind_r, kind_nxt;
  logic [3:0] fwidth_r, fwidth_nxt;
  logic       dbl_r, dbl_nxt;

  // line and item state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [3:0]    grp_r, grp_nxt;
  logic [13:0]   raw_addr_r, raw_addr_nxt;
  logic [AW-1:0] col_addr_r, col_addr_nxt;
  logic [3:0]    iss_cnt_r, iss_cnt_nxt;
  logic [3:0]    width_r, width_nxt;
  logic [3:0]    bitsel_r, bitsel_nxt;
  logic          row_ok_r, row_ok_nxt;
  logic          rd_valid_r, rd_valid_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [23:0]   bits_r, bits_nxt;
  logic [4:0]    cnt_r, cnt_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [23:0]   out_bits_r;
  logic [4:0]    out_cnt_r;
  logic          out_last_r;
  logic          out_load;
  logic [23:0]   load_bits;
  logic [4:0]    load_cnt;
  logic          load_last;

  // font ram port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;

  // decode of the current request and configuration
  logic          in_take;
  logic          slot_free;
  logic          issue;
  logic [4:0]    height;
  logic [13:0]   base;
  logic [3:0]    width_eff;
  logic [13:0]   glyph_off;

  // per-column dot placement
  logic          dot;
  logic          ok0, ok1;
  logic [PW-1:0] pos1;
  logic [4:0]    cnt1;
  logic [4:0]    n_pad;
  logic [PW-1:0] rem_after;
  logic          pad_last;

  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign issue     = (state_r == ST_READ) && (iss_cnt_r < width_r);

  // writes happen only from idle, reads only outside it, so one port serves both
  assign ram_we   = in_take && (in_command == trd_pkg::CMD_WRITE);
  assign ram_addr = (state_r == ST_IDLE) ? fold_addr(in_font_address) : col_addr_r;

  trd_ram #(
    .WIDTH (16),
    .DEPTH (FONT_WORDS)
  ) u_font_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_font_word),
    .rdata (ram_rdata)
  );

  // font geometry from the current configuration
  always_comb begin
    unique case (kind_r)
      trd_pkg::KIND_12ROW: begin
        height = 5'd12;
        base   = 14'(trd_pkg::REGION_WORDS);
      end
      trd_pkg::KIND_16ROW: begin
        height = 5'd16;
        base   = 14'(2 * trd_pkg::REGION_WORDS);
      end
      default: begin
        // kind zero and the spare kind three both use the eight-row font
        height = 5'd8;
        base   = '0;
      end
    endcase
    width_eff = (fwidth_r > 4'(trd_pkg::MAX_COLS)) ? 4'(trd_pkg::MAX_COLS) : fwidth_r;
    // glyph stride is 12 only for 12-column glyphs, 8 for everything else
    glyph_off = {3'd0, in_char_code, 3'd0};
    if (width_eff == 4'(trd_pkg::MAX_COLS)) begin
      glyph_off = glyph_off + {4'd0, in_char_code, 2'd0};
    end
  end

  // dot placement for the column word that has just come back
  always_comb begin
    dot  = row_ok_r ? ram_rdata[bitsel_r] : 1'b0;
    ok0  = (pos_r < PW'(LINE_DOTS)) && (cnt_r < 5'(trd_pkg::GROUP_DOTS));
    pos1 = pos_r + PW'(ok0);
    cnt1 = cnt_r + 5'(ok0);
    ok1  = dbl_r && (pos1 < PW'(LINE_DOTS)) && (cnt1 < 5'(trd_pkg::GROUP_DOTS));
  end

  // end-of-line padding group
  always_comb begin
    n_pad     = (rem_r > PW'(trd_pkg::GROUP_DOTS)) ? 5'(trd_pkg::GROUP_DOTS) : rem_r[4:0];
    rem_after = rem_r - PW'(n_pad);
    pad_last  = (rem_after == '0) || (grp_r == 4'(trd_pkg::MAX_GROUPS - 1));
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    fwidth_nxt   = fwidth_r;
    dbl_nxt      = dbl_r;
    pos_nxt      = pos_r;
    rem_nxt      = rem_r;
    grp_nxt      = grp_r;
    raw_addr_nxt = raw_addr_r;
    col_addr_nxt = col_addr_r;
    iss_cnt_nxt  = iss_cnt_r;
    width_nxt    = width_r;
    bitsel_nxt   = bitsel_r;
    row_ok_nxt   = row_ok_r;
    rd_valid_nxt = issue;
    rd_last_nxt  = issue && (iss_cnt_r == width_r - 4'd1);
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    out_load     = 1'b0;
    load_bits    = bits_r;
    load_cnt     = cnt_r;
    load_last    = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        trd_pkg::CFG_FONT_KIND:    kind_nxt   = cfg_data[1:0];
        trd_pkg::CFG_FONT_WIDTH:   fwidth_nxt = cfg_data;
        trd_pkg::CFG_DOUBLE_WIDTH: dbl_nxt    = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_command)
            trd_pkg::CMD_RENDER: begin
              raw_addr_nxt = base + glyph_off;
              width_nxt    = width_eff;
              row_ok_nxt   = ({1'b0, in_row} < height);
              bitsel_nxt   = 4'(height - 5'd1 - {1'b0, in_row});
              bits_nxt     = '0;
              cnt_nxt      = '0;
              state_nxt    = ST_ADDR;
            end
            trd_pkg::CMD_EOL: begin
              rem_nxt   = (pos_r < PW'(LINE_DOTS)) ? PW'(LINE_DOTS) - pos_r : '0;
              pos_nxt   = '0;
              grp_nxt   = '0;
              state_nxt = ST_EOL;
            end
            // font writes go straight to the ram, unknown commands are dropped
            default: ;
          endcase
        end
      end
      ST_ADDR: begin
        col_addr_nxt = fold_addr(raw_addr_r);
        iss_cnt_nxt  = '0;
        state_nxt    = (width_r == '0) ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        if (issue) begin
          col_addr_nxt = (col_addr_r == AW'(FONT_WORDS - 1)) ? '0 : col_addr_r + AW'(1);
          iss_cnt_nxt  = iss_cnt_r + 4'd1;
        end
        if (rd_valid_r) begin
          if (ok0) begin
            bits_nxt[5'(trd_pkg::GROUP_DOTS - 1) - cnt_r] = dot;
          end
          if (ok1) begin
            bits_nxt[5'(trd_pkg::GROUP_DOTS - 1) - cnt1] = dot;
          end
          cnt_nxt = cnt1 + 5'(ok1);
          pos_nxt = pos1 + PW'(ok1);
          if (rd_last_r) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EOL: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_bits = '0;
          load_cnt  = n_pad;
          load_last = pad_last;
          rem_nxt   = rem_after;
          grp_nxt   = grp_r + 4'd1;
          if (pad_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= '0;
      fwidth_r    <= 4'(trd_pkg::NARROW_COLS);
      dbl_r       <= 1'b0;
      pos_r       <= '0;
      rd_valid_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      fwidth_r    <= fwidth_nxt;
      dbl_r       <= dbl_nxt;
      pos_r       <= pos_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers, always loaded before use
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    grp_r      <= grp_nxt;
    raw_addr_r <= raw_addr_nxt;
    col_addr_r <= col_addr_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    width_r    <= width_nxt;
    bitsel_r   <= bitsel_nxt;
    row_ok_r   <= row_ok_nxt;
    bits_r     <= bits_nxt;
    cnt_r      <= cnt_nxt;
    if (out_load) begin
      out_bits_r <= load_bits;
      out_cnt_r  <= load_cnt;
      out_last_r <= load_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dot_bits  = out_bits_r;
  assign out_dot_count = out_cnt_r;
  assign out_line_end  = out_last_r;

endmodule

`default_nettype wire

>>> src/trd_checker.sv
// port-level checks for the text row dot rasterizer, bound to the top level
// uses trd_pkg and text_row_dot_rasterizer_macros.svh
`default_nettype none

`include "text_row_dot_rasterizer_macros.svh"

module trd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_command,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_dot_bits,
  input wire logic [4:0]  out_dot_count
);

  // a group never holds more than one group's worth of dots
  `TRD_ASSERT_NOW(a_count_range, out_valid, out_dot_count <= 5'(trd_pkg::GROUP_DOTS), "dot count above group size")

  // bits beyond the valid dots stay clear
  `TRD_ASSERT_NOW(a_tail_clear, out_valid, (out_dot_bits << out_dot_count) == 24'd0, "dots set past the dot count")

  // a taken render request makes the block busy, so no request is taken straight after it
  `TRD_ASSERT_NEXT(a_render_busy, in_valid && !in_stall && (in_command == trd_pkg::CMD_RENDER), in_stall, "request taken straight after a render")

  // a held group keeps its dots
  `TRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_dot_bits), "stalled group changed")

endmodule

bind text_row_dot_rasterizer trd_checker u_trd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_dot_bits  (out_dot_bits),
  .out_dot_count (out_dot_count)
);

`default_nettype wire

>>> tb/tb_text_row_dot_rasterizer.sv
// self-checking testbench for the text row dot rasterizer: font loads, glyph row renders,
// line padding and register settings, with random idling on both request and result sides
// depends on trd_pkg and the text_row_dot_rasterizer rtl
`timescale 1ns / 100ps

module tb_text_row_dot_rasterizer;

  localparam int LINE_DOTS  = 384;
  localparam int FONT_WORDS = trd_pkg::ADDR_SPAN;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] KIND_8ROW  = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // cap on printed mismatches, every one is still counted
  localparam int REPORT_CAP = 60;

  typedef struct packed {
    logic [23:0] bits;
    logic [4:0]  count;
    logic        last;
  } dot_group_t;

  // mirror of the block: font store, line position and settings, plus the groups owed
  class dot_row_scoreboard;
    bit [15:0]   glyph_mem [0:FONT_WORDS-1];
    int unsigned line_pos;
    logic [1:0]  kind;
    logic [3:0]  width_reg;
    logic        dbl;
    dot_group_t  expected_groups [$];
    int          errors;
    int          groups_seen;
    int          requests_seen;
    int          reg_writes;

    function new();
      line_pos  = 0;
      kind      = KIND_8ROW;
      width_reg = 4'd8;
      dbl       = 1'b0;
    endfunction

    function void note_config(logic [1:0] idx, logic [3:0] data);
      reg_writes++;
      case (idx)
        trd_pkg::CFG_FONT_KIND:    kind      = data[1:0];
        trd_pkg::CFG_FONT_WIDTH:   width_reg = data;
        trd_pkg::CFG_DOUBLE_WIDTH: dbl       = data[0];
        default: ;
      endcase
    endfunction

    // glyph columns actually read, wide settings saturate
    function int unsigned glyph_columns();
      return (width_reg > trd_pkg::MAX_COLS) ? trd_pkg::MAX_COLS : width_reg;
    endfunction

    function int unsigned column_address(logic [7:0] code, int unsigned c);
      int unsigned base, ncols, stride;
      base = (kind == trd_pkg::KIND_12ROW) ? trd_pkg::REGION_WORDS :
             (kind == trd_pkg::KIND_16ROW) ? 2 * trd_pkg::REGION_WORDS : 0;
      ncols = glyph_columns();
      // widths other than 8 and 12 still sit on the narrow pitch
      stride = (ncols == trd_pkg::NARROW_COLS || ncols == trd_pkg::MAX_COLS) ? ncols
                                                                           : trd_pkg::NARROW_COLS;
      return (base + code * stride + c) % FONT_WORDS;
    endfunction

    function void render_glyph_row(logic [7:0] code, logic [3:0] row);
      int unsigned height, reps, count;
      logic [15:0] w;
      logic        dot;
      dot_group_t  g;
      height = (kind == trd_pkg::KIND_12ROW) ? 12 : (kind == trd_pkg::KIND_16ROW) ? 16 : 8;
      reps   = dbl ? 2 : 1;
      count  = 0;
      g      = '0;
      for (int unsigned c = 0; c < glyph_columns(); c++) begin
        dot = 1'b0;
        if (row < height) begin
          w   = glyph_mem[column_address(code, c)];
          dot = w[height - 1 - row];
        end
        for (int unsigned r = 0; r < reps; r++) begin
          // dots past the line width or the group size are dropped
          if (line_pos < LINE_DOTS && count < trd_pkg::GROUP_DOTS) begin
            g.bits[23 - count] = dot;
            count++;
            line_pos++;
          end
        end
      end
      g.count = 5'(count);
      expected_groups.push_back(g);
    endfunction

    function void pad_line();
      int unsigned rem, k, n;
      dot_group_t  g;
      rem      = (line_pos < LINE_DOTS) ? LINE_DOTS - line_pos : 0;
      line_pos = 0;
      g        = '0;
      if (rem == 0) begin
        g.last = 1'b1;
        expected_groups.push_back(g);
      end else begin
        k = 0;
        while (rem > 0 && k < trd_pkg::MAX_GROUPS) begin
          n       = (rem > trd_pkg::GROUP_DOTS) ? trd_pkg::GROUP_DOTS : rem;
          rem    -= n;
          g.count = 5'(n);
          g.last  = (rem == 0 || k + 1 == trd_pkg::MAX_GROUPS);
          expected_groups.push_back(g);
          k++;
        end
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [13:0] addr, logic [15:0] word,
                               logic [7:0] code, logic [3:0] row);
      requests_seen++;
      case (cmd)
        trd_pkg::CMD_WRITE:  glyph_mem[addr] = word;
        trd_pkg::CMD_RENDER: render_glyph_row(code, row);
        trd_pkg::CMD_EOL:    pad_line();
        default: ;
      endcase
    endfunction

    function void mismatch(string field, logic [23:0] want, logic [23:0] got);
      errors++;
      if (errors <= REPORT_CAP)
        $error("%s: expected %0h, actual %0h", field, want, got);
    endfunction

    function void check_group(logic [23:0] bits, logic [4:0] count, logic last);
      dot_group_t want;
      groups_seen++;
      if (expected_groups.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $error("dot group %0h/%0d/%0b with nothing outstanding", bits, count, last);
        return;
      end
      want = expected_groups.pop_front();
      if (bits !== want.bits)   mismatch("dot_bits", want.bits, bits);
      if (count !== want.count) mismatch("dot_count", 24'(want.count), 24'(count));
      if (last !== want.last)   mismatch("line_end", 24'(want.last), 24'(last));
    endfunction

    function int pending();
      return expected_groups.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [13:0] in_font_address;
  logic [15:0] in_font_word;
  logic [7:0]  in_char_code;
  logic [3:0]  in_row;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_dot_bits;
  logic [4:0]  out_dot_count;
  logic        out_line_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  dot_row_scoreboard sb;

  // font words already given a value, so no render touches an unwritten entry
  bit glyph_loaded [0:FONT_WORDS-1];

  // set for a stretch with no idling on either side
  bit steady;

  text_row_dot_rasterizer #(
    .LINE_DOTS  (LINE_DOTS),
    .FONT_WORDS (FONT_WORDS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_font_address (in_font_address),
    .in_font_word    (in_font_word),
    .in_char_code    (in_char_code),
    .in_row          (in_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dot_bits    (out_dot_bits),
    .out_dot_count   (out_dot_count),
    .out_line_end    (out_line_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure, raised at random about a fifth of the time
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 19);
  end

  // everything is sampled at the edge, before the nonblocking updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        sb.note_config(cfg_index, cfg_data);
      // a group can never belong to a request taken at this same edge
      if (out_valid && !out_stall)
        sb.check_group(out_dot_bits, out_dot_count, out_line_end);
      if (in_valid && !in_stall)
        sb.note_request(in_command, in_font_address, in_font_word, in_char_code, in_row);
    end
  end

  // valid is left high on return so back-to-back requests need no second assignment
  task automatic send_request(logic [1:0] cmd, logic [13:0] addr, logic [15:0] word,
                              logic [7:0] code, logic [3:0] row);
    if (!steady) begin
      while ($urandom_range(0, 99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_font_address <= addr;
    in_font_word    <= word;
    in_char_code    <= code;
    in_row          <= row;
    do @(posedge clk); while (in_stall);
    if (cmd == trd_pkg::CMD_WRITE)
      glyph_loaded[addr] = 1'b1;
  endtask

  task automatic write_word(logic [13:0] addr, logic [15:0] word);
    send_request(trd_pkg::CMD_WRITE, addr, word, 8'($urandom), 4'($urandom));
  endtask

  // loads any missing column of the glyph first, then asks for the row
  task automatic render_char(logic [7:0] code, logic [3:0] row);
    int unsigned ncols, a;
    ncols = sb.glyph_columns();
    // width zero still gets its first column filled
    if (ncols == 0)
      ncols = 1;
    for (int unsigned c = 0; c < ncols; c++) begin
      a = sb.column_address(code, c);
      if (!glyph_loaded[a])
        write_word(14'(a), 16'($urandom));
    end
    send_request(trd_pkg::CMD_RENDER, 14'($urandom), 16'($urandom), code, row);
  endtask

  task automatic end_line();
    send_request(trd_pkg::CMD_EOL, 14'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drops cfg_valid and waits for an edge at the end so the scoreboard holds the new settings
  task automatic apply_config(logic [3:0] kind_data, logic [3:0] width_data,
                              logic [3:0] dbl_data, bit spare_write);
    write_reg(trd_pkg::CFG_FONT_KIND, kind_data);
    write_reg(trd_pkg::CFG_FONT_WIDTH, width_data);
    write_reg(trd_pkg::CFG_DOUBLE_WIDTH, dbl_data);
    if (spare_write)
      write_reg(CFG_UNUSED, 4'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain every owed group, then allow for a render still in flight with nothing owed
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)
      write_word(14'($urandom), 16'($urandom));
    else if (pick < 80)
      // two codes only so glyphs get reused across settings
      render_char(8'($urandom_range(0, 1)), 4'($urandom));
    else if (pick < 92)
      end_line();
    else
      send_request(CMD_UNUSED, 14'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
  endtask

  initial begin
    logic [1:0] kind;
    logic [3:0] fw;
    logic       dw;

    sb              = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    steady          = 1'b0;
    in_valid        = 1'b0;
    in_command      = trd_pkg::CMD_WRITE;
    in_font_address = '0;
    in_font_word    = '0;
    in_char_code    = '0;
    in_row          = '0;
    cfg_valid       = 1'b0;
    cfg_index       = trd_pkg::CFG_FONT_KIND;
    cfg_data        = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // eight-row font: store extremes, top row, row past height, unknown command
    apply_config({2'b00, KIND_8ROW}, 4'd8, 4'd0, 1'b0);
    write_word(14'h0000, 16'h0000);
    write_word(14'h3fff, 16'hffff);
    render_char(8'd0, 4'd0);
    render_char(8'd0, 4'd15);
    send_request(CMD_UNUSED, 14'h3fff, 16'hffff, 8'hff, 4'hf);
    end_line();
    settle();

    // widest double-width glyphs until the line is full, then one more and an empty pad
    apply_config({2'b00, trd_pkg::KIND_16ROW}, 4'd12, 4'd1, 1'b0);
    for (int i = 0; i < 17; i++)
      render_char(8'hff, (i == 0) ? 4'd0 : (i == 1) ? 4'd15 : 4'($urandom));
    end_line();
    settle();

    // spare font kind with width zero, then a fully padded line
    apply_config({2'b00, KIND_SPARE}, 4'd0, 4'd0, 1'b0);
    render_char(8'($urandom), 4'($urandom));
    end_line();
    settle();

    // twelve-row font with a width that saturates
    apply_config({2'b00, trd_pkg::KIND_12ROW}, 4'd15, 4'd1, 1'b0);
    render_char(8'd128, 4'd0);
    render_char(8'd128, 4'd12);
    end_line();
    settle();

    // random settings per phase, one phase with no idling at all
    for (int phase = 0; phase < 5; phase++) begin
      steady = (phase == 2);
      kind   = 2'($urandom_range(0, 3));
      fw     = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 4'd8 : 4'd12)
                                    : 4'($urandom_range(0, 15));
      dw     = 1'($urandom_range(0, 1));
      apply_config({2'($urandom), kind}, fw, {3'($urandom), dw}, phase == 3);
      repeat (6) random_request();
      settle();
    end
    steady = 1'b0;

    $display("%0d requests taken, %0d dot groups compared, %0d register writes, %0d mismatches",
             sb.requests_seen, sb.groups_seen, sb.reg_writes, sb.errors);
    $display("font kinds, widths up to saturation, double width, full and padded lines exercised");
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
